/* design/gso_pkg.sv */
// Shared constants, types and arithmetic helpers for the Gram-Schmidt orthonormaliser.
package gso_pkg;

  localparam int DIM   = 4;
  localparam int CELLS = DIM * DIM;
  localparam int CW    = $clog2(CELLS);
  localparam int RW    = $clog2(DIM);
  localparam int IW    = 3;
  localparam int QW    = 48;
  localparam int DCW   = $clog2(QW);

  typedef enum logic [13:0] {
    ST_LOAD      = 14'b00000000000001,
    ST_COPY      = 14'b00000000000010,
    ST_DOT_MUL   = 14'b00000000000100,
    ST_DOT_ACC   = 14'b00000000001000,
    ST_PROJ_LO   = 14'b00000000010000,
    ST_PROJ_HI   = 14'b00000000100000,
    ST_PROJ_UPD  = 14'b00000001000000,
    ST_SQ_MUL    = 14'b00000010000000,
    ST_SQ_ACC    = 14'b00000100000000,
    ST_SQRT      = 14'b00001000000000,
    ST_DIV_SETUP = 14'b00010000000000,
    ST_DIV       = 14'b00100000000000,
    ST_DIV_DONE  = 14'b01000000000000,
    ST_EMIT      = 14'b10000000000000
  } state_t;

  localparam logic KIND_BASIS = 1'b0;
  localparam logic KIND_NORM  = 1'b1;

  function automatic logic [CW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return CW'(32'(r) * DIM + 32'(c));
  endfunction

  // Signed divide by 65536, rounding toward zero.
  function automatic logic signed [63:0] trunc16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x[63] ? (x + 64'sd65535) : x;
    return t >>> 16;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sh000000007FFFFFFF) r = 32'h7FFFFFFF;
    else if (x < -64'sh0000000080000000) r = 32'h80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

/* design/gram_schmidt_orthonormalizer.sv */
// Top level: classical Gram-Schmidt orthonormaliser with one shared multiplier.
//
// Feed DIM*DIM signed Q16.16 elements row-major on the slave stream, one per
// transaction; row i is vector i. After the last element the block stops taking
// input, orthonormalises the rows, then sends DIM*DIM basis elements row-major
// followed by the DIM norms, the final norm marked with tlast. A row whose norm is
// zero gives zero basis elements and the degenerate flag on all its results.
// While loading, the block is always ready for the next element. The computation
// uses one 33x33 multiplier for every product, a 32-step bit-per-cycle square
// root per row and a 48-step restoring divider per basis element, which a
// degenerate row skips; then one result per cycle while the master side is ready.
module gram_schmidt_orthonormalizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] row, [5:3] col, [37:6] value, [39:38] zero
  output logic [1:0]  m_tuser,   // [0] kind, [1] degenerate
  output logic        m_tlast
);

  gso_pkg::state_t st;

  logic [31:0] in_mem    [gso_pkg::CELLS];
  logic [31:0] basis_mem [gso_pkg::CELLS];
  logic [31:0] norm_mem  [gso_pkg::DIM];
  logic [31:0] work      [gso_pkg::DIM];

  logic [gso_pkg::CW-1:0] load_cnt;
  logic [gso_pkg::IW-1:0] i, j, k;
  logic                   kind;

  logic signed [63:0] acc;
  logic signed [63:0] coef;
  logic signed [63:0] plo;
  logic signed [65:0] prod;
  logic [63:0]        res, sbit;
  logic [32:0]        drem;
  logic [gso_pkg::QW-1:0]  dnum;
  logic [gso_pkg::DCW-1:0] dcnt;
  logic               neg;

  logic [31:0] cur_in, cur_bj, cur_w, norm_i;
  logic signed [32:0] mul_a, mul_b;
  logic [31:0] out_value;

  always_comb begin
    cur_in = in_mem[gso_pkg::cell_addr(i, k)];
    cur_bj = basis_mem[gso_pkg::cell_addr(j, k)];
    cur_w  = work[k[gso_pkg::RW-1:0]];
    norm_i = norm_mem[i[gso_pkg::RW-1:0]];
    case (st)
      gso_pkg::ST_DOT_MUL: begin
        mul_a = {cur_in[31], cur_in};
        mul_b = {cur_bj[31], cur_bj};
      end
      gso_pkg::ST_PROJ_LO: begin
        mul_a = {1'b0, coef[31:0]};
        mul_b = {cur_bj[31], cur_bj};
      end
      gso_pkg::ST_PROJ_HI: begin
        mul_a = {coef[63], coef[63:32]};
        mul_b = {cur_bj[31], cur_bj};
      end
      default: begin
        mul_a = {cur_w[31], cur_w};
        mul_b = {cur_w[31], cur_w};
      end
    endcase
  end

  // Sequencer working values
  logic signed [63:0] dot_sum, proj_full, proj_p, diff;
  logic [64:0]        sq_sum;
  logic [63:0]        sq_acc, sq_t, sqrt_res_next;
  logic [32:0]        drem_sh;
  logic               q_bit;
  logic [31:0]        q_val;

  always_comb begin
    dot_sum   = acc + $signed(prod[63:0]);
    proj_full = plo + $signed({prod[31:0], 32'b0});
    proj_p    = gso_pkg::trunc16(proj_full);
    diff      = $signed({{32{cur_w[31]}}, cur_w}) - proj_p;
    sq_sum    = {1'b0, acc} + {1'b0, prod[63:0]};
    sq_acc    = sq_sum[64] ? '1 : sq_sum[63:0];
    sq_t      = res + sbit;
    sqrt_res_next = ($unsigned(acc) >= sq_t) ? ((res >> 1) + sbit) : (res >> 1);
    drem_sh   = {drem[31:0], dnum[gso_pkg::QW-1]};
    q_bit     = (drem_sh >= {1'b0, norm_i});
    if (!neg) begin
      q_val = (dnum > gso_pkg::QW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : dnum[31:0];
    end else begin
      q_val = (dnum > gso_pkg::QW'(32'h80000000)) ? 32'h80000000 : (32'd0 - dnum[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= gso_pkg::ST_LOAD;
      load_cnt <= '0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      kind     <= gso_pkg::KIND_BASIS;
    end else begin
      case (st)
        gso_pkg::ST_LOAD: begin
          if (s_tvalid) begin
            in_mem[load_cnt] <= s_tdata;
            if (load_cnt == gso_pkg::CW'(gso_pkg::CELLS - 1)) begin
              load_cnt <= '0;
              i  <= '0;
              k  <= '0;
              st <= gso_pkg::ST_COPY;
            end else begin
              load_cnt <= load_cnt + 1'b1;
            end
          end
        end
        gso_pkg::ST_COPY: begin
          work[k[gso_pkg::RW-1:0]] <= cur_in;
          acc     <= '0;
          if (k == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
            k  <= '0;
            j  <= '0;
            st <= (i == '0) ? gso_pkg::ST_SQ_MUL : gso_pkg::ST_DOT_MUL;
          end else begin
            k <= k + 1'b1;
          end
        end
        gso_pkg::ST_DOT_MUL: begin
          prod <= mul_a * mul_b;
          st   <= gso_pkg::ST_DOT_ACC;
        end
        gso_pkg::ST_DOT_ACC: begin
          acc <= dot_sum;
          if (k == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
            coef <= gso_pkg::trunc16(dot_sum);
            k    <= '0;
            st   <= gso_pkg::ST_PROJ_LO;
          end else begin
            k  <= k + 1'b1;
            st <= gso_pkg::ST_DOT_MUL;
          end
        end
        gso_pkg::ST_PROJ_LO: begin
          prod <= mul_a * mul_b;
          st   <= gso_pkg::ST_PROJ_HI;
        end
        gso_pkg::ST_PROJ_HI: begin
          plo  <= $signed(prod[63:0]);
          prod <= mul_a * mul_b;
          st   <= gso_pkg::ST_PROJ_UPD;
        end
        gso_pkg::ST_PROJ_UPD: begin
          work[k[gso_pkg::RW-1:0]] <= gso_pkg::sat32(diff);
          if (k == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
            k   <= '0;
            acc <= '0;
            if (j == i - 1'b1) begin
              st <= gso_pkg::ST_SQ_MUL;
            end else begin
              j  <= j + 1'b1;
              st <= gso_pkg::ST_DOT_MUL;
            end
          end else begin
            k  <= k + 1'b1;
            st <= gso_pkg::ST_PROJ_LO;
          end
        end
        gso_pkg::ST_SQ_MUL: begin
          prod <= mul_a * mul_b;
          st   <= gso_pkg::ST_SQ_ACC;
        end
        gso_pkg::ST_SQ_ACC: begin
          acc <= $signed(sq_acc);
          if (k == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
            k    <= '0;
            res  <= '0;
            sbit <= 64'd1 << 62;
            st   <= gso_pkg::ST_SQRT;
          end else begin
            k  <= k + 1'b1;
            st <= gso_pkg::ST_SQ_MUL;
          end
        end
        gso_pkg::ST_SQRT: begin
          if ($unsigned(acc) >= sq_t) acc <= $signed($unsigned(acc) - sq_t);
          res  <= sqrt_res_next;
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            norm_mem[i[gso_pkg::RW-1:0]] <= (sqrt_res_next > 64'h7FFFFFFF) ? 32'h7FFFFFFF
                                                                          : sqrt_res_next[31:0];
            st <= gso_pkg::ST_DIV_SETUP;
          end
        end
        gso_pkg::ST_DIV_SETUP: begin
          if (norm_i == '0) begin
            basis_mem[gso_pkg::cell_addr(i, k)] <= '0;
            if (k == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
              k <= '0;
              if (i == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
                i    <= '0;
                kind <= gso_pkg::KIND_BASIS;
                st   <= gso_pkg::ST_EMIT;
              end else begin
                i  <= i + 1'b1;
                st <= gso_pkg::ST_COPY;
              end
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            neg  <= cur_w[31];
            dnum <= {(cur_w[31] ? (32'd0 - cur_w) : cur_w), 16'b0};
            drem <= '0;
            dcnt <= '0;
            st   <= gso_pkg::ST_DIV;
          end
        end
        gso_pkg::ST_DIV: begin
          drem <= q_bit ? (drem_sh - {1'b0, norm_i}) : drem_sh;
          dnum <= {dnum[gso_pkg::QW-2:0], q_bit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == gso_pkg::DCW'(gso_pkg::QW - 1)) st <= gso_pkg::ST_DIV_DONE;
        end
        gso_pkg::ST_DIV_DONE: begin
          basis_mem[gso_pkg::cell_addr(i, k)] <= q_val;
          if (k == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
            k <= '0;
            if (i == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
              i    <= '0;
              kind <= gso_pkg::KIND_BASIS;
              st   <= gso_pkg::ST_EMIT;
            end else begin
              i  <= i + 1'b1;
              st <= gso_pkg::ST_COPY;
            end
          end else begin
            k  <= k + 1'b1;
            st <= gso_pkg::ST_DIV_SETUP;
          end
        end
        gso_pkg::ST_EMIT: begin
          if (m_tready) begin
            if (kind == gso_pkg::KIND_BASIS) begin
              if (k == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
                k <= '0;
                if (i == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
                  i    <= '0;
                  kind <= gso_pkg::KIND_NORM;
                end else begin
                  i <= i + 1'b1;
                end
              end else begin
                k <= k + 1'b1;
              end
            end else if (i == gso_pkg::IW'(gso_pkg::DIM - 1)) begin
              i  <= '0;
              st <= gso_pkg::ST_LOAD;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        default: st <= gso_pkg::ST_LOAD;
      endcase
    end
  end

  assign out_value = (kind == gso_pkg::KIND_NORM) ? norm_i : basis_mem[gso_pkg::cell_addr(i, k)];

  assign s_tready = (st == gso_pkg::ST_LOAD);
  assign m_tvalid = (st == gso_pkg::ST_EMIT);
  assign m_tdata  = {2'b00, out_value,
                     ((kind == gso_pkg::KIND_NORM) ? gso_pkg::IW'(0) : k), i};
  assign m_tuser  = {(norm_i == '0), kind};
  assign m_tlast  = (kind == gso_pkg::KIND_NORM) && (i == gso_pkg::IW'(gso_pkg::DIM - 1));

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input and output sides active together");

  a_last_is_norm: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser[0] == gso_pkg::KIND_NORM))
    else $error("tlast on a basis element");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata[37:6] == 32'd0))
    else $error("degenerate row gave a non-zero value");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && load_cnt == gso_pkg::CW'(gso_pkg::CELLS - 1))
    |=> (st == gso_pkg::ST_COPY)) else $error("full matrix did not start a run");
`endif

endmodule
